@@ rtl/epwr_pkg.sv @@
package epwr_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNTER_BITS = 16;
    localparam int WRAP_BITS    = 6;

    localparam int CH_W      = 2;
    localparam int LEVEL_W   = 4;
    localparam int SCALE_W   = 16;
    localparam int LIMIT_W   = 6;
    localparam int DIST_BITS = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd170;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    localparam int TOTAL_W = WRAP_BITS + COUNTER_BITS;
    localparam int PROD_W  = TOTAL_W + SCALE_W;

    localparam longint DIVISOR   = 20000;
    localparam longint DIST_MAX  = (64'd1 << DIST_BITS) - 1;
    localparam longint SAT_LIMIT = (DIST_MAX + 1) * DIVISOR;
    localparam int     REM_W     = $clog2(SAT_LIMIT);

    // 20000 is 625 << 5: shift out the power of two, then a reciprocal multiply
    localparam int     QUO_SHIFT   = 5;
    localparam longint ODD_DIVISOR = DIVISOR >> QUO_SHIFT;
    localparam int     RECIP_SHIFT = 35;
    localparam longint RECIP_M     = ((64'd1 << RECIP_SHIFT) + ODD_DIVISOR - 1) / ODD_DIVISOR;
    localparam int     RECIP_IN_W  = REM_W - QUO_SHIFT;
    localparam int     RECIP_M_W   = $clog2(RECIP_M);
    localparam int     RECIP_W     = RECIP_IN_W + RECIP_M_W;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SCL_IDLE,
        SCL_MUL,
        SCL_CHECK
    } scl_state_t;

    typedef struct packed {
        logic                    tick;
        logic                    rearm;
        logic                    wrapped;
        logic                    cur;
        logic                    prev;
        logic [COUNTER_BITS-1:0] now;
        logic [WRAP_BITS-1:0]    limit;
    } lane_ctl_t;

    typedef struct packed {
        logic                    done;
        logic                    rise;
        logic [WRAP_BITS-1:0]    wrap;
        logic [COUNTER_BITS-1:0] pulse;
    } lane_stat_t;

    typedef struct packed {
        logic                 start;
        logic [TOTAL_W-1:0]   total;
        logic [SCALE_W-1:0]   scale;
        logic [CH_W-1:0]      channel;
        logic                 measured;
    } scl_req_t;

    typedef struct packed {
        logic                 done;
        logic                 busy;
        logic [CH_W-1:0]      channel;
        logic [DIST_BITS-1:0] distance;
        logic                 measured;
    } scl_rsp_t;

endpackage

@@ rtl/echo_pulse_width_ranger.sv @@
// Echo pulse width ranger: four echo channels timed on one shared tick counter.
// s_ channel: s_tuser is op (0 tick, 1 read). s_tdata carries the echo levels
// and the channel to read. A tick updates every lane in the cycle it is taken
// and returns nothing, so ticks go in at one per cycle while no read is busy.
// A read returns one transaction on the m_ channel: channel, distance in cm
// (saturated at 32767, 0 if the channel had no finished measurement) and the
// measured flag in m_tuser. The channel is rearmed when the read is taken.
// A read passes the scaler's multiply step, then the saturation check and the
// divide by 20000 (shift by 5, then a reciprocal multiply for 625), then the
// load of the output register before m_tvalid rises. s_tready stays low from
// a read until its result is in the output register, so one read is in flight
// at a time.
// The output register holds a result while m_tready is low; ticks are taken
// meanwhile until a further read, which waits in the scaler until the register frees.
// cfg_ channel: index 0 distance_scale, 1 overflow_limit, always ready; write
// only while the block is idle. Reset (aresetn low, synchronous) restores
// scale 170 and limit 63, clears the counter and sets every channel waiting.
module echo_pulse_width_ranger (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] echo_levels, [5:4] read_channel, [7:6] zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] result_channel, [16:2] distance_cm, [23:17] zero
    output logic [0:0]  m_tuser,   // [0] measured
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [epwr_pkg::SCALE_W-1:0]       scale_reg;
    logic [epwr_pkg::WRAP_BITS-1:0]     limit_reg;
    logic [epwr_pkg::COUNTER_BITS-1:0]  tick_count_reg;
    logic [epwr_pkg::NUM_CHANNELS-1:0]  prev_levels_reg;

    logic                               in_acc, acc_tick, acc_read;
    logic [epwr_pkg::NUM_CHANNELS-1:0]  levels;
    logic [epwr_pkg::CH_W-1:0]          rd_ch;
    logic [epwr_pkg::COUNTER_BITS-1:0]  now;
    logic                               wrapped;
    logic [epwr_pkg::NUM_CHANNELS-1:0]  rises;

    epwr_pkg::lane_ctl_t                lane_ctl  [epwr_pkg::NUM_CHANNELS];
    epwr_pkg::lane_stat_t               lane_stat [epwr_pkg::NUM_CHANNELS];
    epwr_pkg::lane_stat_t               sel;
    logic                               sel_done;

    epwr_pkg::scl_req_t                 req;
    epwr_pkg::scl_rsp_t                 rsp;
    logic                               out_load;

    logic                               m_valid_reg;
    logic [epwr_pkg::CH_W-1:0]          m_ch_reg;
    logic [epwr_pkg::DIST_BITS-1:0]     m_dist_reg;
    logic                               m_meas_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !rsp.busy;
    assign in_acc    = s_tvalid && s_tready;
    assign acc_tick  = in_acc && (s_tuser[0] == epwr_pkg::OP_TICK);
    assign acc_read  = in_acc && (s_tuser[0] == epwr_pkg::OP_READ);
    assign levels    = epwr_pkg::NUM_CHANNELS'(s_tdata[3:0]);
    assign rd_ch     = s_tdata[5:4];

    assign now     = tick_count_reg + 1'b1;
    assign wrapped = (now == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= epwr_pkg::SCALE_RESET;
            limit_reg <= epwr_pkg::WRAP_BITS'(epwr_pkg::LIMIT_RESET);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                epwr_pkg::REG_DISTANCE_SCALE: scale_reg <= cfg_data;
                epwr_pkg::REG_OVERFLOW_LIMIT:
                    limit_reg <= epwr_pkg::WRAP_BITS'(cfg_data[epwr_pkg::LIMIT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            prev_levels_reg <= '0;
        end else if (acc_tick) begin
            // any channel that starts a measurement clears the shared counter
            tick_count_reg  <= (|rises) ? '0 : now;
            prev_levels_reg <= levels;
        end
    end

    for (genvar i = 0; i < epwr_pkg::NUM_CHANNELS; i++) begin : g_lane
        assign lane_ctl[i].tick    = acc_tick;
        assign lane_ctl[i].rearm   = acc_read && (rd_ch == epwr_pkg::CH_W'(i));
        assign lane_ctl[i].wrapped = wrapped;
        assign lane_ctl[i].cur     = levels[i];
        assign lane_ctl[i].prev    = prev_levels_reg[i];
        assign lane_ctl[i].now     = now;
        assign lane_ctl[i].limit   = limit_reg;
        assign rises[i]            = lane_stat[i].rise;

        epwr_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl[i]),
            .stat    (lane_stat[i])
        );
    end

    // merge: pick the read lane and form its total tick count
    assign sel      = lane_stat[rd_ch];
    assign sel_done = sel.done;

    always_comb begin
        req.start    = acc_read;
        req.scale    = scale_reg;
        req.channel  = rd_ch;
        req.measured = sel_done;
        if (sel_done) begin
            req.total = epwr_pkg::TOTAL_W'({sel.wrap, {epwr_pkg::COUNTER_BITS{1'b0}}})
                      - epwr_pkg::TOTAL_W'(sel.wrap)
                      + epwr_pkg::TOTAL_W'(sel.pulse);
        end else begin
            req.total = '0;
        end
    end

    epwr_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .take    (out_load),
        .rsp     (rsp)
    );

    assign out_load = rsp.done && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_ch_reg   <= rsp.channel;
            m_dist_reg <= rsp.distance;
            m_meas_reg <= rsp.measured;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_dist_reg, m_ch_reg};
    assign m_tuser  = m_meas_reg;

    a_read_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_read |=> !s_tready)
        else $error("read transaction did not occupy the scaler");

    a_unmeasured_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[16:2] == '0))
        else $error("distance nonzero without a finished measurement");

    a_read_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_read && sel_done) |=> !lane_stat[$past(rd_ch)].done)
        else $error("channel not rearmed after its read");

    a_rise_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_tick && (|rises)) |=> (tick_count_reg == '0))
        else $error("shared counter not cleared on a rising edge");

endmodule

@@ rtl/epwr_lane.sv @@
module epwr_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  epwr_pkg::lane_ctl_t    ctl,
    output epwr_pkg::lane_stat_t   stat
);

    epwr_pkg::phase_t                   phase_reg, phase_next;
    logic [epwr_pkg::WRAP_BITS-1:0]     wrap_reg, wrap_next;
    logic [epwr_pkg::COUNTER_BITS-1:0]  pulse_reg, pulse_next;
    logic                               rise;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= epwr_pkg::PH_WAIT;
            wrap_reg  <= '0;
            pulse_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            wrap_reg  <= wrap_next;
            pulse_reg <= pulse_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        wrap_next  = wrap_reg;
        pulse_next = pulse_reg;
        rise       = 1'b0;
        if (ctl.tick) begin
            case (phase_reg)
                epwr_pkg::PH_HIGH: begin
                    // wrap is handled first, a timeout ignores this tick's edge
                    if (ctl.wrapped && (wrap_reg >= ctl.limit)) begin
                        phase_next = epwr_pkg::PH_DONE;
                        pulse_next = epwr_pkg::CNT_MAX;
                    end else begin
                        if (ctl.wrapped) begin
                            wrap_next = wrap_reg + 1'b1;
                        end
                        if (ctl.prev && !ctl.cur) begin
                            phase_next = epwr_pkg::PH_DONE;
                            pulse_next = ctl.now;
                        end
                    end
                end
                epwr_pkg::PH_WAIT: begin
                    if (!ctl.prev && ctl.cur) begin
                        phase_next = epwr_pkg::PH_HIGH;
                        wrap_next  = '0;
                        pulse_next = '0;
                        rise       = 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (ctl.rearm && (phase_reg == epwr_pkg::PH_DONE)) begin
            phase_next = epwr_pkg::PH_WAIT;
            wrap_next  = '0;
        end
    end

    assign stat.done  = (phase_reg == epwr_pkg::PH_DONE);
    assign stat.rise  = rise;
    assign stat.wrap  = wrap_reg;
    assign stat.pulse = pulse_reg;

endmodule

@@ rtl/epwr_scaler.sv @@
module epwr_scaler (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  epwr_pkg::scl_req_t   req,
    input  logic                 take,
    output epwr_pkg::scl_rsp_t   rsp
);

    epwr_pkg::scl_state_t                state_reg, state_next;
    logic                                done_reg, done_next;
    logic [epwr_pkg::TOTAL_W-1:0]        total_reg;
    logic [epwr_pkg::SCALE_W-1:0]        scale_reg;
    logic [epwr_pkg::CH_W-1:0]           ch_reg;
    logic                                meas_reg;
    logic [epwr_pkg::PROD_W-1:0]         prod_reg;
    logic                                sat_reg;
    logic [epwr_pkg::RECIP_W-1:0]        recip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= epwr_pkg::SCL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (req.start && (state_reg == epwr_pkg::SCL_IDLE) && !done_reg) begin
            total_reg <= req.total;
            scale_reg <= req.scale;
            ch_reg    <= req.channel;
            meas_reg  <= req.measured;
        end
        if (state_reg == epwr_pkg::SCL_MUL) begin
            prod_reg <= epwr_pkg::PROD_W'(total_reg) * epwr_pkg::PROD_W'(scale_reg);
        end
        if (state_reg == epwr_pkg::SCL_CHECK) begin
            sat_reg   <= (prod_reg >= epwr_pkg::PROD_W'(epwr_pkg::SAT_LIMIT));
            // below the saturation point the quotient fits the distance field
            recip_reg <= epwr_pkg::RECIP_W'(prod_reg[epwr_pkg::REM_W-1:epwr_pkg::QUO_SHIFT])
                       * epwr_pkg::RECIP_W'(epwr_pkg::RECIP_M);
        end
    end

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        case (state_reg)
            epwr_pkg::SCL_IDLE: begin
                if (done_reg) begin
                    if (take) begin
                        done_next = 1'b0;
                    end
                end else if (req.start) begin
                    state_next = epwr_pkg::SCL_MUL;
                end
            end
            epwr_pkg::SCL_MUL: begin
                state_next = epwr_pkg::SCL_CHECK;
            end
            epwr_pkg::SCL_CHECK: begin
                state_next = epwr_pkg::SCL_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = epwr_pkg::SCL_IDLE;
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = done_reg || (state_reg != epwr_pkg::SCL_IDLE);
    assign rsp.channel  = ch_reg;
    assign rsp.distance = sat_reg ? epwr_pkg::DIST_BITS'(epwr_pkg::DIST_MAX)
                                  : recip_reg[epwr_pkg::RECIP_SHIFT +: epwr_pkg::DIST_BITS];
    assign rsp.measured = meas_reg;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // index values with no register behind them
    localparam logic [epwr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [epwr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int IDLE_LIMIT      = 5000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [epwr_pkg::CH_W-1:0]      channel;
        logic [epwr_pkg::DIST_BITS-1:0] distance;
        logic                           measured;
    } range_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [3:0] echo_levels, [5:4] read_channel, [7:6] zero
    logic [0:0]  s_tuser = '0;   // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [1:0] result_channel, [16:2] distance_cm, [23:17] zero
    logic [0:0]  m_tuser;        // [0] measured
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predicted block state
    logic [epwr_pkg::COUNTER_BITS-1:0] tick_count;
    logic [epwr_pkg::LEVEL_W-1:0]      prev_levels;
    epwr_pkg::phase_t                  ch_phase [epwr_pkg::NUM_CHANNELS];
    logic [epwr_pkg::WRAP_BITS-1:0]    wrap_cnt [epwr_pkg::NUM_CHANNELS];
    logic [epwr_pkg::COUNTER_BITS-1:0] pulse_ticks [epwr_pkg::NUM_CHANNELS];
    logic [epwr_pkg::SCALE_W-1:0]      dist_scale;
    logic [epwr_pkg::LIMIT_W-1:0]      wrap_limit;

    range_result_t expected_ranges [$];

    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int n_ticks = 0;
    int n_reads = 0;
    int n_measured = 0;
    int n_timeouts = 0;
    int n_cfg_writes = 0;
    logic [epwr_pkg::LEVEL_W-1:0] echo_drive = '0;

    echo_pulse_width_ranger i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void reset_ranger_state();
        tick_count  = '0;
        prev_levels = '0;
        dist_scale  = epwr_pkg::SCALE_RESET;
        wrap_limit  = epwr_pkg::LIMIT_RESET;
        for (int c = 0; c < epwr_pkg::NUM_CHANNELS; c++) begin
            ch_phase[c]    = epwr_pkg::PH_WAIT;
            wrap_cnt[c]    = '0;
            pulse_ticks[c] = '0;
        end
    endfunction

    function automatic void advance_echo_timer(logic [epwr_pkg::LEVEL_W-1:0] lv);
        logic [epwr_pkg::COUNTER_BITS-1:0] now;
        logic wrapped;
        logic clear;
        logic skip;
        now = tick_count + 1'b1;
        wrapped = (now == '0);
        clear = 1'b0;
        for (int c = 0; c < epwr_pkg::NUM_CHANNELS; c++) begin
            skip = (ch_phase[c] == epwr_pkg::PH_DONE);
            // wrap is handled before the edge, a timeout hides this tick's edge
            if (!skip && ch_phase[c] == epwr_pkg::PH_HIGH && wrapped) begin
                if (wrap_cnt[c] >= wrap_limit) begin
                    ch_phase[c]    = epwr_pkg::PH_DONE;
                    pulse_ticks[c] = epwr_pkg::CNT_MAX;
                    n_timeouts++;
                    skip = 1'b1;
                end else begin
                    wrap_cnt[c] = wrap_cnt[c] + 1'b1;
                end
            end
            if (!skip) begin
                if (ch_phase[c] == epwr_pkg::PH_HIGH) begin
                    if (prev_levels[c] && !lv[c]) begin
                        ch_phase[c]    = epwr_pkg::PH_DONE;
                        pulse_ticks[c] = now;
                    end
                end else if (!prev_levels[c] && lv[c]) begin
                    ch_phase[c]    = epwr_pkg::PH_HIGH;
                    wrap_cnt[c]    = '0;
                    pulse_ticks[c] = '0;
                    clear = 1'b1;
                end
            end
        end
        tick_count  = clear ? '0 : now;
        prev_levels = lv;
    endfunction

    function automatic range_result_t range_of_channel(logic [epwr_pkg::CH_W-1:0] ch);
        range_result_t r;
        longint unsigned total;
        longint unsigned dist_cm;
        r.channel  = ch;
        r.distance = '0;
        r.measured = 1'b0;
        if (ch_phase[ch] == epwr_pkg::PH_DONE) begin
            total   = wrap_cnt[ch] * 64'(epwr_pkg::CNT_MAX) + 64'(pulse_ticks[ch]);
            dist_cm = total * 64'(dist_scale) / epwr_pkg::DIVISOR;
            if (dist_cm > epwr_pkg::DIST_MAX)
                dist_cm = epwr_pkg::DIST_MAX;
            r.distance   = dist_cm[epwr_pkg::DIST_BITS-1:0];
            r.measured   = 1'b1;
            ch_phase[ch] = epwr_pkg::PH_WAIT;
            wrap_cnt[ch] = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // result checker and predictor, both in acceptance order
    always @(posedge aclk) begin
        range_result_t head;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_ranges.size() == 0) begin
                    report_mismatch("result transaction with none pending", 0, 1);
                end else begin
                    head = expected_ranges.pop_front();
                    if (m_tdata[1:0] !== head.channel)
                        report_mismatch("result_channel", head.channel, m_tdata[1:0]);
                    if (m_tdata[16:2] !== head.distance)
                        report_mismatch("distance_cm", head.distance, m_tdata[16:2]);
                    if (m_tuser[0] !== head.measured)
                        report_mismatch("measured", head.measured, m_tuser[0]);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == epwr_pkg::OP_TICK) begin
                    advance_echo_timer(s_tdata[3:0]);
                    n_ticks++;
                end else begin
                    head = range_of_channel(s_tdata[5:4]);
                    expected_ranges.push_back(head);
                    n_reads++;
                    if (head.measured)
                        n_measured++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                n_cfg_writes++;
                if (cfg_index == epwr_pkg::REG_DISTANCE_SCALE)
                    dist_scale = cfg_data[epwr_pkg::SCALE_W-1:0];
                else if (cfg_index == epwr_pkg::REG_OVERFLOW_LIMIT)
                    wrap_limit = cfg_data[epwr_pkg::LIMIT_W-1:0];
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [epwr_pkg::LEVEL_W-1:0] lv,
                             input logic [epwr_pkg::CH_W-1:0] ch);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, ch, lv};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_tick(input logic [epwr_pkg::LEVEL_W-1:0] lv);
        send_item(epwr_pkg::OP_TICK, lv, epwr_pkg::CH_W'($urandom));
    endtask

    task automatic send_read(input logic [epwr_pkg::CH_W-1:0] ch);
        send_item(epwr_pkg::OP_READ, epwr_pkg::LEVEL_W'($urandom), ch);
    endtask

    // sender pauses until every pending distance has come back
    task automatic wait_for_ranges();
        s_tvalid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [epwr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [epwr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_item();
        int r;
        logic [epwr_pkg::LEVEL_W-1:0] flips;
        r = $urandom_range(99);
        if (r < 20) begin
            send_read(epwr_pkg::CH_W'($urandom));
        end else begin
            if (r < 26) begin
                echo_drive = epwr_pkg::LEVEL_W'($urandom);
            end else begin
                // slow toggling so most pulses are clean rise, hold, fall
                for (int c = 0; c < epwr_pkg::LEVEL_W; c++)
                    flips[c] = ($urandom_range(5) == 0);
                echo_drive = echo_drive ^ flips;
            end
            send_tick(echo_drive);
        end
    endtask

    task automatic test_reads_after_reset();
        for (int c = 0; c < epwr_pkg::NUM_CHANNELS; c++)
            send_read(epwr_pkg::CH_W'(c));
        wait_for_ranges();
    endtask

    task automatic test_edges_and_rearm();
        write_reg(epwr_pkg::REG_DISTANCE_SCALE, 16'hFFFF);
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
        // all four rise together, then fall together
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'hF);
        send_tick(4'h0);
        for (int c = 0; c < epwr_pkg::NUM_CHANNELS; c++)
            send_read(epwr_pkg::CH_W'(c));
        // a later rise on another channel clears the shared counter
        send_tick(4'h1);
        send_tick(4'h1);
        send_tick(4'h3);
        send_tick(4'h2);
        send_tick(4'h0);
        // done channel ignores this rise
        send_tick(4'h1);
        send_read(2'd0);
        send_read(2'd1);
        // level still high after the read does not start a measurement
        send_tick(4'h1);
        send_tick(4'h0);
        send_read(2'd0);
        send_read(2'd2);
        wait_for_ranges();
    endtask

    task automatic test_output_backpressure();
        write_reg(epwr_pkg::REG_DISTANCE_SCALE, 16'd5000);
        write_reg(epwr_pkg::REG_OVERFLOW_LIMIT, 16'd63);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left <= HOLD_OFF_CYCLES;
        for (int i = 0; i < 60; i++) begin
            if (i % 4 == 3)
                send_read(epwr_pkg::CH_W'($urandom));
            else
                send_random_item();
        end
        wait_for_ranges();
    endtask

    task automatic run_random_phase(input int n, input int idle, input int stall,
                                    input logic [15:0] scale, input logic [15:0] limit_data);
        wait_for_ranges();
        write_reg(epwr_pkg::REG_DISTANCE_SCALE, scale);
        write_reg(epwr_pkg::REG_OVERFLOW_LIMIT, limit_data);
        tx_idle_pct  = idle;
        rx_stall_pct = stall;
        repeat (n) send_random_item();
        wait_for_ranges();
    endtask

    task automatic test_random_traffic();
        run_random_phase(375, 0, 0, epwr_pkg::SCALE_RESET, 16'(epwr_pkg::LIMIT_RESET));
        run_random_phase(375, 84, 0, 16'hFFFF, 16'd1);
        run_random_phase(375, 0, 84, 16'd0, 16'($urandom_range(63)));
        run_random_phase(375, 29, 29, 16'($urandom), 16'($urandom));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        reset_ranger_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reads_after_reset();
        test_edges_and_rearm();
        test_output_backpressure();
        test_random_traffic();

        wait_for_ranges();
        repeat (40) @(posedge aclk);
        if (expected_ranges.size() != 0)
            report_mismatch("results never delivered", 0, expected_ranges.size());
        $display("covered %0d ticks and %0d reads, %0d with a finished measurement",
                 n_ticks, n_reads, n_measured);
        $display("%0d wrap timeouts, %0d register writes, %0d mismatches",
                 n_timeouts, n_cfg_writes, error_count);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
